@@ hw/rtl/dua_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_pkg
// Shared types and constants of the debounced up/down auto-repeat counter.
// ----------------------------------------------------------------------------
package dua_pkg;

  // field widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS  = 2'd2;

  // register reset values
  localparam logic [VALUE_W-1:0] INITIAL_VALUE_RST = 32'd10;
  localparam logic [TICK_W-1:0]  HOLD_TICKS_RST    = 8'd50;
  localparam logic [TICK_W-1:0]  REPEAT_TICKS_RST  = 8'd10;

  // step direction codes
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // key tracking mode
  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_UP_ARMED = 5'b00010,
    MODE_UP_HELD  = 5'b00100,
    MODE_DN_ARMED = 5'b01000,
    MODE_DN_HELD  = 5'b10000
  } key_mode_t;

endpackage

@@ hw/rtl/dua_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_in_if
// Sample tick request channel: key levels of one tick.
// ----------------------------------------------------------------------------
interface dua_in_if;
  logic valid;
  logic ready;
  logic up_pressed;
  logic down_pressed;

  modport source(output valid, output up_pressed, output down_pressed, input ready);
  modport sink(input valid, input up_pressed, input down_pressed, output ready);
endinterface

@@ hw/rtl/dua_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_out_if
// Step result channel: new setting value and its direction.
// ----------------------------------------------------------------------------
interface dua_out_if;
  import dua_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] setting_value;
  logic               step_direction;

  modport source(output valid, output setting_value, output step_direction, input ready);
  modport sink(input valid, input setting_value, input step_direction, output ready);
endinterface

@@ hw/rtl/dua_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dua_cfg_if;
  import dua_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VALUE_W-1:0]   data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/debounced_updown_auto_repeat_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_updown_auto_repeat_top
// Debounced up/down setting counter with hold-to-repeat stepping.
// ----------------------------------------------------------------------------
// Each request is one sample tick with the levels of the up and down keys.
// A key counts once it reads pressed on two ticks in a row; the setting value
// then steps by one (wrapping at 32 bits) and a result is sent. While the key
// stays down, a hold counter runs to hold_ticks, then the value steps every
// repeat_ticks ticks. Up wins when both keys arrive together from idle.
// Throughput is one tick per clock unless a stepping tick stalls: the tick
// is captured in an input register, then key tracking runs combinationally
// into the result register that offers the result. Ready falls only when a
// stepping tick waits behind an untaken result. Configuration writes are
// always accepted; initial_value is stored but never loads the setting value.
// ----------------------------------------------------------------------------
module debounced_updown_auto_repeat_top (
  input logic      clk,
  input logic      rst_n,
  dua_in_if.sink   in_chan,
  dua_out_if.source out_chan,
  dua_cfg_if.sink  cfg_chan
);
  import dua_pkg::*;

  // configuration registers
  logic [VALUE_W-1:0] init_value_r;
  logic [TICK_W-1:0]  hold_ticks_r;
  logic [TICK_W-1:0]  repeat_ticks_r;

  // input stage
  logic s1_valid_r;
  logic s1_up_r;
  logic s1_dn_r;

  // key tracking state
  key_mode_t          mode_r, mode_nxt;
  logic [TICK_W-1:0]  hold_cnt_r, hold_cnt_nxt;
  logic [TICK_W-1:0]  rep_cnt_r, rep_cnt_nxt;
  logic [VALUE_W-1:0] cur_r, cur_nxt;

  // result register
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_dir_r;

  logic               step;
  logic               step_dir;
  logic               out_free;
  logic               s1_fire;
  logic               load_out;
  logic [TICK_W-1:0]  period;
  logic               hold_run;
  logic [TICK_W-1:0]  hold_ht;
  logic [TICK_W-1:0]  rep_ht;
  logic               rep_due;

  // configuration writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_value_r   <= INITIAL_VALUE_RST;
      hold_ticks_r   <= HOLD_TICKS_RST;
      repeat_ticks_r <= REPEAT_TICKS_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_INITIAL_VALUE: init_value_r   <= cfg_chan.data;
        CFG_HOLD_TICKS:    hold_ticks_r   <= cfg_chan.data[TICK_W-1:0];
        CFG_REPEAT_TICKS:  repeat_ticks_r <= cfg_chan.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake between stages
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && (!step || out_free);
  assign load_out      = s1_fire && step;
  assign in_chan.ready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_up_r <= in_chan.up_pressed;
      s1_dn_r <= in_chan.down_pressed;
    end
  end

  // held-key tick: hold phase, then repeat counting
  assign period   = (repeat_ticks_r == '0) ? TICK_W'(1) : repeat_ticks_r;
  assign hold_run = hold_cnt_r < hold_ticks_r;
  assign hold_ht  = hold_run ? hold_cnt_r + TICK_W'(1) : hold_cnt_r;
  assign rep_ht   = hold_run ? rep_cnt_r : rep_cnt_r + TICK_W'(1);
  assign rep_due  = rep_ht >= period;

  // key mode transitions
  always_comb begin
    mode_nxt     = mode_r;
    hold_cnt_nxt = hold_cnt_r;
    rep_cnt_nxt  = rep_cnt_r;
    step         = 1'b0;
    step_dir     = DIR_UP;
    unique case (mode_r)
      MODE_UP_ARMED: begin
        if (s1_up_r) begin
          hold_cnt_nxt = '0;
          rep_cnt_nxt  = '0;
          mode_nxt     = MODE_UP_HELD;
          step         = 1'b1;
        end else begin
          mode_nxt = s1_dn_r ? MODE_DN_ARMED : MODE_IDLE;
        end
      end
      MODE_UP_HELD: begin
        if (s1_up_r) begin
          hold_cnt_nxt = hold_ht;
          rep_cnt_nxt  = rep_due ? '0 : rep_ht;
          step         = rep_due;
        end else begin
          mode_nxt = s1_dn_r ? MODE_DN_ARMED : MODE_IDLE;
        end
      end
      MODE_DN_ARMED: begin
        step_dir = DIR_DOWN;
        if (s1_dn_r) begin
          hold_cnt_nxt = '0;
          rep_cnt_nxt  = '0;
          mode_nxt     = MODE_DN_HELD;
          step         = 1'b1;
        end else begin
          mode_nxt = s1_up_r ? MODE_UP_ARMED : MODE_IDLE;
        end
      end
      MODE_DN_HELD: begin
        step_dir = DIR_DOWN;
        if (s1_dn_r) begin
          hold_cnt_nxt = hold_ht;
          rep_cnt_nxt  = rep_due ? '0 : rep_ht;
          step         = rep_due;
        end else begin
          mode_nxt = s1_up_r ? MODE_UP_ARMED : MODE_IDLE;
        end
      end
      default: begin
        if (s1_up_r) begin
          mode_nxt = MODE_UP_ARMED;
        end else if (s1_dn_r) begin
          mode_nxt = MODE_DN_ARMED;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
    endcase
  end

  // stepped value
  assign cur_nxt = (step_dir == DIR_DOWN) ? cur_r - VALUE_W'(1) : cur_r + VALUE_W'(1);

  // tracking state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      hold_cnt_r <= '0;
      rep_cnt_r  <= '0;
      cur_r      <= INITIAL_VALUE_RST;
    end else if (s1_fire) begin
      mode_r     <= mode_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      if (step) begin
        cur_r <= cur_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= cur_nxt;
      out_dir_r   <= step_dir;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.setting_value  = out_value_r;
  assign out_chan.step_direction = out_dir_r;

`ifndef SYNTHESIS
  // a waiting result always shows the current setting value
  a_out_matches_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_value_r == cur_r)
    else $error("pending result differs from setting value");

  // the value only moves by one step when a result is loaded
  a_value_steps: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (cur_r == $past(cur_r) + VALUE_W'(1)) ||
                 (cur_r == $past(cur_r) - VALUE_W'(1)))
    else $error("setting value did not move by one");

  // without a result the value stays put
  a_value_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !load_out |=> $stable(cur_r))
    else $error("setting value changed without a result");

  // input stall only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid_r && out_valid_r && step)
    else $error("input stalled without a blocked result");
`endif

endmodule

@@ test/dua_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_checker
// Watches the tick, step and configuration channels of the up/down counter.
// ----------------------------------------------------------------------------
// Keeps its own copy of the key tracking state and of the registers. Each
// accepted tick request is run through that copy; a tick that steps the value
// queues the new value and direction. Each accepted result is compared field
// by field with the oldest queued step. The failure count and the number of
// steps still owed go to the testbench top.
// ----------------------------------------------------------------------------
module dua_checker
  import dua_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dua_in_if           in_mon,
  dua_out_if          out_mon,
  dua_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending_steps
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               dir;
  } step_t;

  // register copies
  logic [VALUE_W-1:0] initial_value_reg;
  logic [TICK_W-1:0]  hold_limit;
  logic [TICK_W-1:0]  repeat_period;

  // key tracking copy
  key_mode_t          mode;
  logic [TICK_W-1:0]  hold_cnt;
  logic [TICK_W-1:0]  repeat_cnt;
  logic [VALUE_W-1:0] setting;

  step_t       steps_due[$];
  int unsigned reported;

  // one tick of a held key, true when an auto repeat step falls due
  function automatic bit repeat_due();
    logic [TICK_W-1:0] period;
    period = repeat_period;
    if (period == '0) period = TICK_W'(1);
    if (hold_cnt < hold_limit) hold_cnt++;
    else repeat_cnt++;
    if (repeat_cnt >= period) begin
      repeat_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the key tracking by one tick, true when the value steps
  function automatic bit next_step(input logic up, input logic dn, output step_t st);
    bit   stepped;
    logic going_down;
    stepped    = 1'b0;
    going_down = 1'b0;
    case (mode)
      MODE_UP_ARMED: begin
        if (up) begin
          hold_cnt   = '0;
          repeat_cnt = '0;
          mode       = MODE_UP_HELD;
          stepped    = 1'b1;
        end else begin
          mode = dn ? MODE_DN_ARMED : MODE_IDLE;
        end
      end
      MODE_UP_HELD: begin
        if (up) stepped = repeat_due();
        else mode = dn ? MODE_DN_ARMED : MODE_IDLE;
      end
      MODE_DN_ARMED: begin
        if (dn) begin
          hold_cnt   = '0;
          repeat_cnt = '0;
          mode       = MODE_DN_HELD;
          stepped    = 1'b1;
          going_down = 1'b1;
        end else begin
          mode = up ? MODE_UP_ARMED : MODE_IDLE;
        end
      end
      MODE_DN_HELD: begin
        if (dn) begin
          stepped    = repeat_due();
          going_down = 1'b1;
        end else begin
          mode = up ? MODE_UP_ARMED : MODE_IDLE;
        end
      end
      default: begin
        // up wins when both keys show up together
        if (up) mode = MODE_UP_ARMED;
        else if (dn) mode = MODE_DN_ARMED;
        else mode = MODE_IDLE;
      end
    endcase
    if (stepped) setting = going_down ? setting - VALUE_W'(1) : setting + VALUE_W'(1);
    st.value = setting;
    st.dir   = going_down ? DIR_DOWN : DIR_UP;
    return stepped;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (reported < 10) begin
      reported++;
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk) begin
    step_t want;
    step_t got;
    if (!rst_n) begin
      initial_value_reg = INITIAL_VALUE_RST;
      hold_limit        = HOLD_TICKS_RST;
      repeat_period     = REPEAT_TICKS_RST;
      mode              = MODE_IDLE;
      hold_cnt          = '0;
      repeat_cnt        = '0;
      setting           = INITIAL_VALUE_RST;
      fail_count        = 0;
      reported          = 0;
      steps_due.delete();
    end else begin
      // configuration writes; the initial value copy is stored but never used
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_INITIAL_VALUE: initial_value_reg = cfg_mon.data;
          CFG_HOLD_TICKS:    hold_limit        = cfg_mon.data[TICK_W-1:0];
          CFG_REPEAT_TICKS:  repeat_period     = cfg_mon.data[TICK_W-1:0];
          default: ;
        endcase
      end

      // compare each result with the oldest owed step
      if (out_mon.valid && out_mon.ready) begin
        got.value = out_mon.setting_value;
        got.dir   = out_mon.step_direction;
        if (steps_due.size() == 0) begin
          note_failure($sformatf("result value %h dir %0d with no step owed",
                                 got.value, got.dir));
        end else begin
          want = steps_due.pop_front();
          if (got.value !== want.value || got.dir !== want.dir)
            note_failure($sformatf("expected value %h dir %0d, got value %h dir %0d",
                                   want.value, want.dir, got.value, got.dir));
        end
      end

      // predict accepted tick requests
      if (in_mon.valid && in_mon.ready) begin
        if (next_step(in_mon.up_pressed, in_mon.down_pressed, want))
          steps_due.push_back(want);
      end
    end
    pending_steps = steps_due.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the debounced up/down auto-repeat setting counter.
// ----------------------------------------------------------------------------
// Drives key sample ticks through a series of register settings: a short
// directed run of press, bounce and both-key cases, wrap-around in both
// directions, a key held through a full 255-tick hold phase, and random
// press sequences with bounce and noise. Sender gaps and result stalls are
// random. The checker beside the block predicts and compares every step.
// ----------------------------------------------------------------------------
module tb_top;
  import dua_pkg::*;

  // index past the end of the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending_steps;
  int unsigned burst_left = 0;

  dua_in_if  in_chan();
  dua_out_if out_chan();
  dua_cfg_if cfg_chan();

  debounced_updown_auto_repeat_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  dua_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .fail_count    (fail_count),
    .pending_steps (pending_steps)
  );

  always #10 clk = ~clk;

  // gap before a request: bursts with none, mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one tick request; valid stays high on return
  task automatic send_tick(input logic up, input logic dn);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.up_pressed   <= up;
    in_chan.down_pressed <= dn;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // hold one key for len ticks, optionally with bounce and other-key noise
  task automatic hold_key(input bit up_key, input int unsigned len, input bit bouncy);
    logic main_lvl;
    logic other_lvl;
    for (int unsigned i = 0; i < len; i++) begin
      main_lvl  = bouncy ? ($urandom_range(0, 19) != 0) : 1'b1;
      other_lvl = bouncy ? ($urandom_range(0, 7) == 0) : 1'b0;
      if (up_key) send_tick(main_lvl, other_lvl);
      else send_tick(other_lvl, main_lvl);
    end
  endtask

  // stop sending until every owed step has arrived, then let the block go idle
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending_steps != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random presses with random content, plus bounce and noise bursts
  task automatic run_random(input int unsigned count, input int unsigned max_press);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 80) begin
        len = $urandom_range(1, max_press);
        hold_key(1'($urandom_range(0, 1)), len, 1'b1);
        sent += len;
        len = $urandom_range(1, 3);
        repeat (len) send_tick(1'b0, 1'b0);
        sent += len;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent += len;
      end
    end
  endtask

  // result side: ready runs high for a while, or stalls short or long
  initial begin : result_sink
    int unsigned span;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 60) begin
        out_chan.ready <= 1'b1;
        span = $urandom_range(1, 40);
      end else begin
        out_chan.ready <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      repeat (span) @(posedge clk);
    end
  end

  // stimulus: {up, down} per directed tick
  initial begin : stimulus
    logic [1:0] directed_ticks [17];
    directed_ticks = '{2'b00, 2'b10, 2'b00, 2'b01, 2'b00, 2'b11, 2'b11, 2'b01, 2'b01,
                       2'b11, 2'b10, 2'b01, 2'b00, 2'b10, 2'b10, 2'b11, 2'b00};
    in_chan.valid        <= 1'b0;
    in_chan.up_pressed   <= 1'b0;
    in_chan.down_pressed <= 1'b0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.index       <= CFG_INITIAL_VALUE;
    cfg_chan.data        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: single-tick bounces, both keys, key hand-over
    foreach (directed_ticks[i]) send_tick(directed_ticks[i][1], directed_ticks[i][0]);
    settle();

    // zero hold and zero repeat period: steps every held tick, wrap both ways
    write_reg(CFG_HOLD_TICKS, 32'd0);
    write_reg(CFG_REPEAT_TICKS, 32'd0);
    write_reg(CFG_INITIAL_VALUE, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_INDEX, 32'h0000_0005);
    hold_key(1'b0, 20, 1'b0);
    send_tick(1'b0, 1'b0);
    hold_key(1'b1, 20, 1'b0);
    send_tick(1'b0, 1'b0);
    run_random(20, 12);
    settle();

    // short hold and period
    write_reg(CFG_HOLD_TICKS, 32'd3);
    write_reg(CFG_REPEAT_TICKS, 32'd2);
    write_reg(CFG_INITIAL_VALUE, 32'd0);
    run_random(30, 15);
    settle();

    // longest hold, then a step on every tick
    write_reg(CFG_HOLD_TICKS, 32'd255);
    write_reg(CFG_REPEAT_TICKS, 32'd1);
    hold_key(1'b0, 262, 1'b0);
    send_tick(1'b0, 1'b0);
    run_random(10, 6);
    settle();

    // longest repeat period
    write_reg(CFG_HOLD_TICKS, 32'd1);
    write_reg(CFG_REPEAT_TICKS, 32'd255);
    run_random(20, 10);
    settle();

    // back to reset-like timing with long presses
    write_reg(CFG_HOLD_TICKS, 32'd50);
    write_reg(CFG_REPEAT_TICKS, 32'd10);
    write_reg(CFG_INITIAL_VALUE, 32'd123);
    run_random(50, 80);
    settle();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_steps == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dua_pkg.sv
hw/rtl/dua_in_if.sv
hw/rtl/dua_out_if.sv
hw/rtl/dua_cfg_if.sv
hw/rtl/debounced_updown_auto_repeat_top.sv
test/dua_checker.sv
test/tb_top.sv
